// ===== src/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg: shared types and codes for the infix to postfix converter
// Token kinds, result kinds, error codes, payload words and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

  // input token kinds; operator codes double as stack entry codes
  typedef enum logic [2:0] {
    TK_NUM   = 3'd0,
    TK_PLUS  = 3'd1,
    TK_MINUS = 3'd2,
    TK_TIMES = 3'd3,
    TK_DIV   = 3'd4,
    TK_OPEN  = 3'd5,
    TK_CLOSE = 3'd6,
    TK_END   = 3'd7
  } tok_kind_t;

  // result kinds
  localparam logic [2:0] OK_NUM = 3'd0;
  localparam logic [2:0] OK_END = 3'd5;
  localparam logic [2:0] OK_ERR = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OVF   = 2'd1;
  localparam logic [1:0] ERR_CLOSE = 2'd2;
  localparam logic [1:0] ERR_OPEN  = 2'd3;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [31:0] token_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] out_value;
    logic [1:0]  error_code;
    logic        last;
  } out_word_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } ctrl_state_t;

  // source of a result word
  typedef enum logic [1:0] {
    EM_NUM,
    EM_TOP,
    EM_ERR,
    EM_END
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      emit;
    emit_sel_t emit_sel;
    logic [1:0] err_code;
    logic      last;
    logic      set_open;
    logic      clr_open;
  } dp_cmd_t;

  typedef struct packed {
    tok_kind_t tok_kind;
    logic      out_free;
    logic      sp_empty;
    logic      sp_multi;
    logic      sp_full;
    logic      top_cand;
    logic      sec_cand;
    logic      top_open;
    logic      open_seen;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/i2p_dpath.sv =====
// ----------------------------------------------------------------------------
// i2p_dpath: converter datapath
// Token register, operator stack memory with two registered read ports
// (top and second entry), stack pointer and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_dpath
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_data,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  tok_kind_t         tok_kind_r;
  logic [31:0]       tok_value_r;
  logic              open_seen_r;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [2:0]        stk_mem [STACK_DEPTH];
  logic [2:0]        top_r, sec_r;
  logic [SP_W-1:0]   sp_m1, sp_m2;
  logic              out_valid_r;
  out_word_t         out_word_r, word_nxt;
  logic              mode_all;

  // token register and leftover open flag
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok_kind_r  <= tok_kind_t'(in_data.token_kind);
      tok_value_r <= in_data.token_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_seen_r <= 1'b0;
    end else if (cmd.load || cmd.clr_open) begin
      open_seen_r <= 1'b0;
    end else if (cmd.set_open) begin
      open_seen_r <= 1'b1;
    end
  end

  // stack pointer
  always_comb begin
    sp_nxt = sp_r;
    if (cmd.push) begin
      sp_nxt = sp_r + SP_W'(1);
    end else if (cmd.pop) begin
      sp_nxt = sp_r - SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  assign sp_m1 = sp_nxt - SP_W'(1);
  assign sp_m2 = sp_nxt - SP_W'(2);

  // stack memory, top and second entries prefetched for the next pointer
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[sp_r[ADDR_W-1:0]] <= tok_kind_r;
    end
    if (sp_nxt != '0) begin
      if (cmd.push) begin
        top_r <= tok_kind_r;
      end else begin
        top_r <= stk_mem[sp_m1[ADDR_W-1:0]];
      end
    end
    if (sp_nxt > SP_W'(1)) begin
      sec_r <= stk_mem[sp_m2[ADDR_W-1:0]];
    end
  end

  // pop candidates: plus, minus and close pop everything down to an open
  assign mode_all = (tok_kind_r == TK_PLUS) || (tok_kind_r == TK_MINUS) ||
                    (tok_kind_r == TK_CLOSE);

  function automatic logic is_cand(input logic [2:0] code, input logic all_ops);
    logic hi;
    hi = (code == TK_TIMES) || (code == TK_DIV);
    return (code != TK_OPEN) && (all_ops || hi);
  endfunction

  always_comb begin
    stat.tok_kind  = tok_kind_r;
    stat.out_free  = !out_valid_r || out_ready;
    stat.sp_empty  = (sp_r == '0);
    stat.sp_multi  = (sp_r > SP_W'(1));
    stat.sp_full   = (sp_r == SP_W'(STACK_DEPTH));
    stat.top_cand  = (sp_r != '0) && is_cand(top_r, mode_all);
    stat.sec_cand  = (sp_r > SP_W'(1)) && is_cand(sec_r, mode_all);
    stat.top_open  = (top_r == TK_OPEN);
    stat.open_seen = open_seen_r;
  end

  // result word
  always_comb begin
    word_nxt = '0;
    word_nxt.last = cmd.last;
    unique case (cmd.emit_sel)
      EM_NUM: begin
        word_nxt.out_kind  = OK_NUM;
        word_nxt.out_value = tok_value_r;
      end
      EM_TOP: begin
        word_nxt.out_kind = top_r;
      end
      EM_ERR: begin
        word_nxt.out_kind   = OK_ERR;
        word_nxt.error_code = cmd.err_code;
      end
      EM_END: begin
        word_nxt.out_kind = OK_END;
      end
      default: begin
        word_nxt.out_kind = OK_END;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

// ===== src/i2p_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2p_ctrl: converter controller
// Takes one token in idle, then steps once per cycle while the output is
// free: emit a result, pop, push or finish, as token and stack top decide.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_ctrl
  import i2p_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dp_stat_t  stat,
  output dp_cmd_t        cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    logic done;
    done      = 1'b0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.emit_sel = EM_TOP;
    cmd.err_code = ERR_NONE;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WORK;
        end
      end

      ST_WORK: begin
        if (stat.out_free) begin
          unique case (stat.tok_kind) inside
            TK_NUM: begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EM_NUM;
              cmd.last     = 1'b1;
              done         = 1'b1;
            end
            TK_PLUS, TK_MINUS, TK_TIMES, TK_DIV: begin
              if (stat.top_cand) begin
                // the push after the final pop gives no result
                cmd.emit = 1'b1;
                cmd.pop  = 1'b1;
                cmd.last = !stat.sec_cand;
              end else if (stat.sp_full) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_ERR;
                cmd.err_code = ERR_OVF;
                cmd.last     = 1'b1;
                done         = 1'b1;
              end else begin
                cmd.push = 1'b1;
                done     = 1'b1;
              end
            end
            TK_OPEN: begin
              if (stat.sp_full) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_ERR;
                cmd.err_code = ERR_OVF;
                cmd.last     = 1'b1;
              end else begin
                cmd.push = 1'b1;
              end
              done = 1'b1;
            end
            TK_CLOSE: begin
              if (stat.top_cand) begin
                // last unless the stack runs dry with no open left
                cmd.emit = 1'b1;
                cmd.pop  = 1'b1;
                cmd.last = stat.sp_multi && !stat.sec_cand;
              end else if (!stat.sp_empty) begin
                cmd.pop = 1'b1;
                done    = 1'b1;
              end else begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_ERR;
                cmd.err_code = ERR_CLOSE;
                cmd.last     = 1'b1;
                done         = 1'b1;
              end
            end
            TK_END: begin
              if (!stat.sp_empty) begin
                // flush: drop opens, emit operators
                cmd.pop = 1'b1;
                if (stat.top_open) begin
                  cmd.set_open = 1'b1;
                end else begin
                  cmd.emit = 1'b1;
                end
              end else if (stat.open_seen) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_ERR;
                cmd.err_code = ERR_OPEN;
                cmd.clr_open = 1'b1;
              end else begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_END;
                cmd.last     = 1'b1;
                done         = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting yard infix to postfix token converter
// Operator stack with two precedence levels, left associative; stack
// overflow, unmatched close and leftover open give error results.
// ----------------------------------------------------------------------------
//
//   channel   ports                          word
//   input     in_valid  in_ready  in_data    token_kind, token_value
//   output    out_valid out_ready out_data   out_kind, out_value,
//                                            error_code, last
//
// A token is taken in an idle cycle; after that the controller steps through
// each result, each stack pop and the final push. The single output register
// passes at most one result per cycle; a stalled output register holds the
// controller until the word is taken.
// Reset (rst_n low at a clock edge) empties the stack; entries themselves
// are not cleared and are read only after being pushed.
`default_nettype none

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack and result path
  i2p_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/i2p_checker.sv =====
// ----------------------------------------------------------------------------
// i2p_checker: port level checks for the infix to postfix converter
// Watches the top level's channels and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_checker
  import i2p_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one token at a time: no new word right after one is taken
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a token is in work");

  // error code only on error results
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.out_kind != OK_ERR) |-> out_data.error_code == ERR_NONE)
    else $error("error code on a non-error result");

  // end marker always closes its token's results
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.out_kind == OK_END) |-> out_data.last)
    else $error("end marker without last");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: infix to postfix converter check
// Drives infix token words through the input handshake and compares every
// postfix word with a shunting yard predictor kept in this file. A short
// table covers the extremes and the error paths. Random expressions follow,
// mostly well formed, some broken or pure noise. Both sides pause at random.
// ----------------------------------------------------------------------------
module testbench
  import i2p_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH   = 32;
  localparam int RANDOM_TOKENS = 180;
  localparam int DRAIN_CYCLES  = STACK_DEPTH + 8;
  localparam int REPORT_CAP    = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // one row of the directed table; typed rows give their single result word
  typedef struct {
    tok_kind_t   kind;
    logic [31:0] value;
    int          reps;
    bit          typed;
    logic [2:0]  res_kind;
    logic [1:0]  res_err;
  } plan_row_t;

  plan_row_t plan[$];

  // predictor state: operator stack and its fill level
  logic [2:0] op_stack[STACK_DEPTH];
  int         op_count = 0;

  // postfix words still owed by the block, oldest first
  out_word_t postfix_due[$];

  int  tokens_sent = 0;
  int  words_checked = 0;
  int  mismatches = 0;
  int  reports = 0;
  int  ovf_errs = 0;
  int  close_errs = 0;
  int  open_errs = 0;
  int  end_marks = 0;
  bit  source_calm = 1'b0;
  bit  sink_calm = 1'b0;
  int  sink_stall = 0;
  int  sink_cycles = 0;

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // pause length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic out_word_t make_word(logic [2:0] k, logic [31:0] v, logic [1:0] e);
    out_word_t w;
    w.out_kind   = k;
    w.out_value  = v;
    w.error_code = e;
    w.last       = 1'b0;
    return w;
  endfunction

  // pop operators off the top; times/divide only when only_high is set
  function automatic void pop_ops(bit only_high, ref out_word_t res[$]);
    logic [2:0] top;
    while (op_count > 0) begin
      top = op_stack[op_count-1];
      if (top == TK_OPEN) break;
      if (only_high && top != TK_TIMES && top != TK_DIV) break;
      res = {res, make_word(top, '0, ERR_NONE)};
      op_count--;
    end
  endfunction

  // push an operator or open paren, or flag overflow and drop the token
  function automatic void push_op(logic [2:0] code, ref out_word_t res[$]);
    if (op_count >= STACK_DEPTH) begin
      res = {res, make_word(OK_ERR, '0, ERR_OVF)};
    end else begin
      op_stack[op_count] = code;
      op_count++;
    end
  endfunction

  // shunting yard step: postfix words released by one infix token
  function automatic void shunt_token(in_word_t tok, ref out_word_t res[$]);
    tok_kind_t kind;
    bit        open_found;
    kind = tok_kind_t'(tok.token_kind);
    open_found = 1'b0;
    res.delete();
    case (kind)
      TK_NUM: begin
        res = {res, make_word(OK_NUM, tok.token_value, ERR_NONE)};
      end
      TK_PLUS, TK_MINUS: begin
        pop_ops(1'b0, res);
        push_op(kind, res);
      end
      TK_TIMES, TK_DIV: begin
        pop_ops(1'b1, res);
        push_op(kind, res);
      end
      TK_OPEN: begin
        push_op(TK_OPEN, res);
      end
      TK_CLOSE: begin
        pop_ops(1'b0, res);
        if (op_count > 0) op_count--;
        else res = {res, make_word(OK_ERR, '0, ERR_CLOSE)};
      end
      default: begin
        // end of expression: flush, dropping open parens
        while (op_count > 0) begin
          if (op_stack[op_count-1] == TK_OPEN) open_found = 1'b1;
          else res = {res, make_word(op_stack[op_count-1], '0, ERR_NONE)};
          op_count--;
        end
        if (open_found) res = {res, make_word(OK_ERR, '0, ERR_OPEN)};
        res = {res, make_word(OK_END, '0, ERR_NONE)};
      end
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
  endfunction

  // offer one word, wait for the handshake, then queue what it releases
  task automatic send_token(input in_word_t tok, input bit typed, input out_word_t typed_word);
    out_word_t produced[$];
    int        gap;
    in_valid <= 1'b1;
    in_data  <= tok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shunt_token(tok, produced);
    if (typed) begin
      produced.delete();
      produced = {produced, typed_word};
    end
    foreach (produced[i]) begin
      postfix_due = {postfix_due, produced[i]};
      if (produced[i].out_kind == OK_END) end_marks++;
      if (produced[i].out_kind == OK_ERR) begin
        case (produced[i].error_code)
          ERR_OVF:   ovf_errs++;
          ERR_CLOSE: close_errs++;
          default:   open_errs++;
        endcase
      end
    end
    tokens_sent++;
    gap = pick_gap(source_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random value rides along on every token; only numbers use it
  task automatic send_plain(input tok_kind_t kind);
    in_word_t w;
    w.token_kind  = kind;
    w.token_value = $urandom();
    send_token(w, 1'b0, '0);
  endtask

  // one expression: deep ones can nest far enough to overflow, broken ones
  // may carry a stray token and may lose their end
  task automatic send_expression(input bit deep, input bit broken);
    int nest;
    int operands;
    int target;
    int step;
    int noise_at;
    int open_pct;
    bit need_operand;
    bit done;
    nest = 0;
    operands = 0;
    step = 0;
    need_operand = 1'b1;
    done = 1'b0;
    target = deep ? $urandom_range(8, 14) : $urandom_range(1, 6);
    open_pct = deep ? 75 : 20;
    noise_at = broken ? int'($urandom_range(0, 12)) : -1;
    while (!done) begin
      if (step == noise_at) send_plain(tok_kind_t'($urandom_range(0, 7)));
      step++;
      if (need_operand) begin
        if ($urandom_range(0, 99) < open_pct) begin
          send_plain(TK_OPEN);
          nest++;
        end else begin
          send_plain(TK_NUM);
          operands++;
          need_operand = 1'b0;
        end
      end else if (nest > 0 && (operands >= target || $urandom_range(0, 99) < 25)) begin
        send_plain(TK_CLOSE);
        nest--;
      end else if (operands >= target) begin
        if (!(broken && $urandom_range(0, 2) == 0)) send_plain(TK_END);
        done = 1'b1;
      end else begin
        send_plain(tok_kind_t'($urandom_range(TK_PLUS, TK_DIV)));
        need_operand = 1'b1;
      end
    end
  endtask

  function automatic void add_row(tok_kind_t kind, logic [31:0] value, int reps, int typed,
                                  logic [2:0] res_kind, logic [1:0] res_err);
    plan_row_t r;
    r.kind     = kind;
    r.value    = value;
    r.reps     = reps;
    r.typed    = (typed != 0);
    r.res_kind = res_kind;
    r.res_err  = res_err;
    plan = {plan, r};
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    if (reports < REPORT_CAP) begin
      reports++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result side: check each accepted word, then pick the next ready value
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (postfix_due.size() == 0) begin
        mismatches++;
        if (reports < REPORT_CAP) begin
          reports++;
          $display("%0t ns: word with none expected, actual %0h", $time, out_data);
        end
      end else begin
        want = postfix_due.pop_front();
        if (out_data.out_kind != want.out_kind)
          report_field("out_kind", 32'(want.out_kind), 32'(out_data.out_kind));
        if (out_data.out_value != want.out_value)
          report_field("out_value", want.out_value, out_data.out_value);
        if (out_data.error_code != want.error_code)
          report_field("error_code", 32'(want.error_code), 32'(out_data.error_code));
        if (out_data.last != want.last)
          report_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
    sink_cycles++;
    if (sink_cycles % 64 == 0) sink_calm = ($urandom_range(0, 3) == 0);
    if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else begin
      sink_stall = pick_gap(sink_calm);
      out_ready <= (sink_stall == 0);
    end
  end

  // stimulus and end of run
  initial begin
    out_word_t typed_word;
    in_word_t  tok;
    int        random_goal;
    int        r;

    // directed table
    add_row(TK_CLOSE, 32'h0,        1, 1, OK_ERR, ERR_CLOSE);  // close on empty stack
    add_row(TK_END,   32'h0,        1, 1, OK_END, ERR_NONE);   // end on empty stack
    add_row(TK_NUM,   32'h0,        1, 1, OK_NUM, ERR_NONE);
    add_row(TK_NUM,   32'hFFFFFFFF, 1, 1, OK_NUM, ERR_NONE);
    add_row(TK_PLUS,  32'hFFFFFFFF, 1, 0, OK_NUM, ERR_NONE);
    add_row(TK_NUM,   32'h5,        1, 1, OK_NUM, ERR_NONE);
    add_row(TK_TIMES, 32'h0,        1, 0, OK_NUM, ERR_NONE);   // stays over plus
    add_row(TK_NUM,   32'hAAAAAAAA, 1, 1, OK_NUM, ERR_NONE);
    add_row(TK_MINUS, 32'h0,        1, 0, OK_NUM, ERR_NONE);   // pops times and plus
    add_row(TK_NUM,   32'h55555555, 1, 1, OK_NUM, ERR_NONE);
    add_row(TK_DIV,   32'h0,        1, 0, OK_NUM, ERR_NONE);
    add_row(TK_NUM,   32'h3,        1, 1, OK_NUM, ERR_NONE);
    add_row(TK_TIMES, 32'h0,        1, 0, OK_NUM, ERR_NONE);   // pops divide only
    add_row(TK_OPEN,  32'h0,        1, 0, OK_NUM, ERR_NONE);
    add_row(TK_NUM,   32'h1,        1, 1, OK_NUM, ERR_NONE);
    add_row(TK_MINUS, 32'h0,        1, 0, OK_NUM, ERR_NONE);
    add_row(TK_NUM,   32'h2,        1, 1, OK_NUM, ERR_NONE);
    add_row(TK_CLOSE, 32'h0,        1, 0, OK_NUM, ERR_NONE);
    add_row(TK_END,   32'h0,        1, 0, OK_NUM, ERR_NONE);
    add_row(TK_PLUS,  32'h0,        1, 0, OK_NUM, ERR_NONE);
    add_row(TK_CLOSE, 32'h0,        1, 0, OK_NUM, ERR_NONE);   // pops plus, then unmatched
    add_row(TK_OPEN,  32'h0,        STACK_DEPTH, 0, OK_NUM, ERR_NONE);
    add_row(TK_DIV,   32'h0,        1, 1, OK_ERR, ERR_OVF);    // full stack
    add_row(TK_OPEN,  32'h0,        1, 1, OK_ERR, ERR_OVF);
    add_row(TK_END,   32'h0,        1, 0, OK_NUM, ERR_NONE);   // leftover opens
    add_row(TK_OPEN,  32'h0,        1, 0, OK_NUM, ERR_NONE);
    add_row(TK_TIMES, 32'h0,        1, 0, OK_NUM, ERR_NONE);
    add_row(TK_END,   32'h0,        1, 0, OK_NUM, ERR_NONE);   // times, open error, end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      typed_word = make_word(plan[i].res_kind,
                             (plan[i].res_kind == OK_NUM) ? plan[i].value : 32'h0,
                             plan[i].res_err);
      typed_word.last = 1'b1;
      tok.token_kind  = plan[i].kind;
      tok.token_value = plan[i].value;
      repeat (plan[i].reps) send_token(tok, plan[i].typed, typed_word);
    end

    // random expressions, broken ones and noise
    random_goal = tokens_sent + RANDOM_TOKENS;
    while (tokens_sent < random_goal) begin
      source_calm = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) send_expression($urandom_range(0, 9) == 0, 1'b0);
      else if (r < 90) send_expression($urandom_range(0, 9) == 0, 1'b1);
      else repeat ($urandom_range(1, 4)) send_plain(tok_kind_t'($urandom_range(0, 7)));
    end
    send_plain(TK_END);
    in_valid <= 1'b0;

    // drain
    while (postfix_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d tokens in, %0d words checked, %0d end markers",
             tokens_sent, words_checked, end_marks);
    $display("errors seen: %0d overflow, %0d unmatched close, %0d leftover open",
             ovf_errs, close_errs, open_errs);
    if (mismatches == 0 && postfix_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("timeout with %0d words outstanding", postfix_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== infix_to_postfix_converter.f =====
src/i2p_pkg.sv
src/i2p_dpath.sv
src/i2p_ctrl.sv
src/infix_to_postfix_converter.sv
src/i2p_checker.sv
verif/testbench.sv
